>>> rtl/sttok_pkg.sv
// Source tokenizer package: token kinds, field widths, result bundle types
// and the operator lookup functions. No dependencies.
package sttok_pkg;

  localparam int LINE_WIDTH_DEF = 16;
  localparam int COL_WIDTH_DEF  = 16;
  localparam int FIELD_W        = 16;
  localparam int KIND_W         = 6;
  localparam int MAX_RESULTS    = 3;
  localparam int CNT_W          = $clog2(MAX_RESULTS + 1);
  localparam int IDX_W          = $clog2(MAX_RESULTS);

  localparam logic [KIND_W-1:0] KIND_NUMBER        = 6'd0;
  localparam logic [KIND_W-1:0] KIND_IDENT         = 6'd1;
  localparam logic [KIND_W-1:0] KIND_TRIPLE_EQUALS = 6'd2;
  localparam logic [KIND_W-1:0] KIND_LSH_EQUALS    = 6'd3;
  localparam logic [KIND_W-1:0] KIND_RSH_EQUALS    = 6'd4;
  localparam logic [KIND_W-1:0] KIND_DOT           = 6'd34;
  localparam logic [KIND_W-1:0] KIND_INVALID       = 6'd51;

  localparam logic [7:0] CH_NEWLINE = 8'd10;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [FIELD_W-1:0] line;
    logic [FIELD_W-1:0] start_col;
    logic [FIELD_W-1:0] end_col;
  } sttok_tok_t;

  typedef struct packed {
    logic [CNT_W-1:0]                   count;
    sttok_tok_t [MAX_RESULTS-1:0]       tok;
  } sttok_bundle_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) || (c == "_");
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == " ") || ((c >= 8'd9) && (c <= 8'd13));
  endfunction

  // Single-character operators; KIND_INVALID for anything else.
  function automatic logic [KIND_W-1:0] single_kind(input logic [7:0] c);
    logic [KIND_W-1:0] k;
    case (c)
      "(": k = 6'd26;
      ")": k = 6'd27;
      "[": k = 6'd28;
      "]": k = 6'd29;
      "{": k = 6'd30;
      "}": k = 6'd31;
      ":": k = 6'd32;
      ";": k = 6'd33;
      ".": k = 6'd34;
      ",": k = 6'd35;
      "@": k = 6'd36;
      "=": k = 6'd37;
      "<": k = 6'd38;
      ">": k = 6'd39;
      "!": k = 6'd40;
      "?": k = 6'd41;
      "+": k = 6'd42;
      "-": k = 6'd43;
      "*": k = 6'd44;
      "/": k = 6'd45;
      "^": k = 6'd46;
      "%": k = 6'd47;
      "~": k = 6'd48;
      "|": k = 6'd49;
      "&": k = 6'd50;
      default: k = KIND_INVALID;
    endcase
    return k;
  endfunction

  // Two-character operators; KIND_INVALID when the pair is not one.
  function automatic logic [KIND_W-1:0] pair_kind(input logic [7:0] a, input logic [7:0] b);
    logic [KIND_W-1:0] k;
    case ({a, b})
      {"-", ">"}: k = 6'd5;
      {"+", "+"}: k = 6'd6;
      {"-", "-"}: k = 6'd7;
      {"+", "="}: k = 6'd8;
      {"-", "="}: k = 6'd9;
      {"*", "="}: k = 6'd10;
      {"/", "="}: k = 6'd11;
      {"^", "="}: k = 6'd12;
      {"%", "="}: k = 6'd13;
      {"|", "="}: k = 6'd14;
      {"&", "="}: k = 6'd15;
      {"<", ">"}: k = 6'd16;
      {"=", "="}: k = 6'd17;
      {"!", "="}: k = 6'd18;
      {"<", "="}: k = 6'd19;
      {">", "="}: k = 6'd20;
      {"|", "|"}: k = 6'd21;
      {"&", "&"}: k = 6'd22;
      {">", "<"}: k = 6'd23;
      {"<", "<"}: k = 6'd24;
      {">", ">"}: k = 6'd25;
      default:    k = KIND_INVALID;
    endcase
    return k;
  endfunction

  // First character of some two-character operator.
  function automatic logic can_extend(input logic [7:0] c);
    logic r;
    case (c)
      "-", "+", "*", "/", "^", "%", "|", "&", "<", ">", "=", "!": r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

endpackage

>>> rtl/sttok_in_if.sv
// Source byte channel: valid/ready handshake carrying cmd and char_code.
// Depends on nothing.
interface sttok_in_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] char_code;

  modport source (output valid, cmd, char_code, input ready);
  modport sink   (input valid, cmd, char_code, output ready);
endinterface

>>> rtl/sttok_out_if.sv
// Token channel: valid/ready handshake carrying one token per transaction.
// Depends on nothing.
interface sttok_out_if;
  logic        valid;
  logic        ready;
  logic [5:0]  token_kind;
  logic [15:0] line_number;
  logic [15:0] start_column;
  logic [15:0] end_column;
  logic        last;

  modport source (output valid, token_kind, line_number, start_column, end_column, last,
                  input ready);
  modport sink   (input valid, token_kind, line_number, start_column, end_column, last,
                  output ready);
endinterface

>>> rtl/sttok_scan.sv
// Scanner: input register, lexer state and the per-byte state update that
// builds a bundle of up to three tokens. Depends on sttok_pkg, sttok_in_if.
module sttok_scan #(
  parameter int LINE_WIDTH = sttok_pkg::LINE_WIDTH_DEF,
  parameter int COL_WIDTH  = sttok_pkg::COL_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  sttok_in_if.sink              src,
  input  logic                  free,
  output logic                  push,
  output sttok_pkg::sttok_bundle_t bundle
);
  import sttok_pkg::*;

  typedef enum logic [2:0] {
    MODE_IDLE, MODE_INT, MODE_INTDOT, MODE_FRAC, MODE_DOT, MODE_IDENT, MODE_OP1, MODE_OP2
  } mode_t;

  localparam logic [LINE_WIDTH-1:0] LINE_MAX = {LINE_WIDTH{1'b1}};
  localparam logic [COL_WIDTH-1:0]  COL_MAX  = {COL_WIDTH{1'b1}};

  logic                  in_valid;
  logic                  in_cmd;
  logic [7:0]            in_char;
  mode_t                 mode, mode_next;
  logic [LINE_WIDTH-1:0] line, line_next;
  logic [COL_WIDTH-1:0]  col, col_next;
  logic [COL_WIDTH-1:0]  tstart, tstart_next;
  logic [COL_WIDTH-1:0]  dot_col, dot_col_next;
  logic [7:0]            held, held_next;

  logic                  adv;
  logic                  do_flush;
  logic                  do_start;
  logic [COL_WIDTH-1:0]  cur;
  logic [FIELD_W-1:0]    prev16, cur16, tstart16, dot16, line16;
  logic [CNT_W-1:0]      cnt;
  sttok_tok_t [MAX_RESULTS-1:0] slot;

  assign adv       = in_valid && free;
  assign src.ready = !in_valid || free;
  assign push      = adv && (cnt != '0);

  assign cur      = (col == COL_MAX) ? col : col + 1'b1;
  assign prev16   = FIELD_W'(col);
  assign cur16    = FIELD_W'(cur);
  assign tstart16 = FIELD_W'(tstart);
  assign dot16    = FIELD_W'(dot_col);
  assign line16   = FIELD_W'(line);

  always_comb begin
    mode_next    = mode;
    line_next    = line;
    col_next     = col;
    tstart_next  = tstart;
    dot_col_next = dot_col;
    held_next    = held;
    do_flush     = 1'b0;
    do_start     = 1'b0;
    cnt          = '0;
    slot         = '0;

    if (in_cmd) begin
      do_flush = 1'b1;
    end else if (in_char == CH_NEWLINE) begin
      do_flush = 1'b1;
      col_next = '0;
      if (line != LINE_MAX) begin
        line_next = line + 1'b1;
      end
    end else begin
      col_next = cur;
      case (mode)
        MODE_IDLE: begin
          do_start = 1'b1;
        end
        MODE_INT: begin
          if (in_char == ".") begin
            dot_col_next = col;
            mode_next    = MODE_INTDOT;
          end else if (!is_digit(in_char)) begin
            do_flush = 1'b1;
            do_start = 1'b1;
          end
        end
        MODE_INTDOT, MODE_DOT: begin
          if (is_digit(in_char)) begin
            mode_next = MODE_FRAC;
          end else begin
            do_flush = 1'b1;
            do_start = 1'b1;
          end
        end
        MODE_FRAC: begin
          if (!is_digit(in_char)) begin
            do_flush = 1'b1;
            do_start = 1'b1;
          end
        end
        MODE_IDENT: begin
          if (!(is_alpha(in_char) || is_digit(in_char))) begin
            do_flush = 1'b1;
            do_start = 1'b1;
          end
        end
        MODE_OP1: begin
          // doubled < > = may still grow into a three-character operator
          if (in_char == held && (in_char == "<" || in_char == ">" || in_char == "=")) begin
            mode_next = MODE_OP2;
          end else if (pair_kind(held, in_char) != KIND_INVALID) begin
            slot[0]   = '{pair_kind(held, in_char), line16, tstart16, cur16};
            cnt       = CNT_W'(1);
            mode_next = MODE_IDLE;
          end else begin
            do_flush = 1'b1;
            do_start = 1'b1;
          end
        end
        MODE_OP2: begin
          if (in_char == "=") begin
            if (held == "=") begin
              slot[0] = '{KIND_TRIPLE_EQUALS, line16, tstart16, cur16};
            end else if (held == "<") begin
              slot[0] = '{KIND_LSH_EQUALS, line16, tstart16, cur16};
            end else begin
              slot[0] = '{KIND_RSH_EQUALS, line16, tstart16, cur16};
            end
            cnt       = CNT_W'(1);
            mode_next = MODE_IDLE;
          end else begin
            do_flush = 1'b1;
            do_start = 1'b1;
          end
        end
        default: begin
          mode_next = MODE_IDLE;
        end
      endcase
    end

    // close the pending token
    if (do_flush) begin
      mode_next = MODE_IDLE;
      case (mode)
        MODE_INT, MODE_FRAC: begin
          slot[0] = '{KIND_NUMBER, line16, tstart16, prev16};
          cnt     = CNT_W'(1);
        end
        MODE_INTDOT: begin
          slot[0] = '{KIND_NUMBER, line16, tstart16, dot16};
          slot[1] = '{KIND_DOT, line16, prev16, prev16};
          cnt     = CNT_W'(2);
        end
        MODE_DOT: begin
          slot[0] = '{KIND_DOT, line16, tstart16, tstart16};
          cnt     = CNT_W'(1);
        end
        MODE_IDENT: begin
          slot[0] = '{KIND_IDENT, line16, tstart16, prev16};
          cnt     = CNT_W'(1);
        end
        MODE_OP1: begin
          slot[0] = '{single_kind(held), line16, tstart16, tstart16};
          cnt     = CNT_W'(1);
        end
        MODE_OP2: begin
          slot[0] = '{pair_kind(held, held), line16, tstart16, prev16};
          cnt     = CNT_W'(1);
        end
        default: begin
          cnt = '0;
        end
      endcase
    end

    // open a new token on the current byte
    if (do_start && !is_space(in_char)) begin
      tstart_next = cur;
      if (is_digit(in_char)) begin
        mode_next = MODE_INT;
      end else if (in_char == ".") begin
        mode_next = MODE_DOT;
      end else if (is_alpha(in_char)) begin
        mode_next = MODE_IDENT;
      end else if (can_extend(in_char)) begin
        mode_next = MODE_OP1;
        held_next = in_char;
      end else begin
        slot[cnt[IDX_W-1:0]] = '{single_kind(in_char), line16, cur16, cur16};
        cnt                  = cnt + 1'b1;
      end
    end

    // end of source: back to the start of a fresh text
    if (in_cmd) begin
      line_next = LINE_WIDTH'(1);
      col_next  = '0;
    end
  end

  assign bundle = '{cnt, slot};

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      mode     <= MODE_IDLE;
      line     <= LINE_WIDTH'(1);
      col      <= '0;
      tstart   <= '0;
      dot_col  <= '0;
      held     <= '0;
    end else begin
      if (src.ready) begin
        in_valid <= src.valid;
        in_cmd   <= src.cmd;
        in_char  <= src.char_code;
      end
      if (adv) begin
        mode    <= mode_next;
        line    <= line_next;
        col     <= col_next;
        tstart  <= tstart_next;
        dot_col <= dot_col_next;
        held    <= held_next;
      end
    end
  end

endmodule

>>> rtl/sttok_emit.sv
// Result register: holds one token bundle and hands its tokens out one per
// transaction. Depends on sttok_pkg, sttok_out_if.
module sttok_emit (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     push,
  input  sttok_pkg::sttok_bundle_t bundle,
  output logic                     free,
  sttok_out_if.source              tok
);
  import sttok_pkg::*;

  logic              held_valid;
  sttok_bundle_t     held_bundle;
  logic [IDX_W-1:0]  idx;
  logic              is_last;
  sttok_tok_t        cur_tok;

  assign cur_tok = held_bundle.tok[idx];
  assign is_last = (CNT_W'(idx) == held_bundle.count - 1'b1);
  assign free    = !held_valid || (tok.ready && is_last);

  assign tok.valid        = held_valid;
  assign tok.token_kind   = cur_tok.kind;
  assign tok.line_number  = cur_tok.line;
  assign tok.start_column = cur_tok.start_col;
  assign tok.end_column   = cur_tok.end_col;
  assign tok.last         = is_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
      idx        <= '0;
    end else if (push) begin
      held_valid  <= 1'b1;
      held_bundle <= bundle;
      idx         <= '0;
    end else if (held_valid && tok.ready) begin
      if (is_last) begin
        held_valid <= 1'b0;
      end else begin
        idx <= idx + 1'b1;
      end
    end
  end

endmodule

>>> rtl/source_tokenizer_top.sv
// Source tokenizer, top level: input register and scanner feeding the
// token result register. Depends on sttok_pkg, both channel interfaces,
// sttok_scan and sttok_emit.
//
// Takes one source byte (or an end-of-source command) per transaction on src
// and returns tokens on tok, each with kind, line and first/last column; last
// marks the final token caused by one byte. A byte is accepted every cycle as
// long as the token side keeps up: every token takes one transaction on tok,
// so a byte that closes n tokens (at most three) holds the input until all
// n are taken, and the sustained rate is set by the single-token-per-cycle
// result register. A byte passes the input register, then the result
// register, before its first token appears. Line and column counters saturate
// at 2^LINE_WIDTH-1 and 2^COL_WIDTH-1; outputs carry their low 16 bits.
module source_tokenizer_top #(
  parameter int LINE_WIDTH = sttok_pkg::LINE_WIDTH_DEF,
  parameter int COL_WIDTH  = sttok_pkg::COL_WIDTH_DEF
) (
  input  logic         clk,
  input  logic         rst,
  sttok_in_if.sink     src,
  sttok_out_if.source  tok
);
  import sttok_pkg::*;

  logic          free;
  logic          push;
  sttok_bundle_t bundle;

  sttok_scan #(
    .LINE_WIDTH (LINE_WIDTH),
    .COL_WIDTH  (COL_WIDTH)
  ) u_scan (
    .clk    (clk),
    .rst    (rst),
    .src    (src),
    .free   (free),
    .push   (push),
    .bundle (bundle)
  );

  sttok_emit u_emit (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .bundle (bundle),
    .free   (free),
    .tok    (tok)
  );

endmodule

>>> rtl/sttok_checker.sv
// Port-level checks for the source tokenizer and the bind that attaches
// them to source_tokenizer_top. Depends on sttok_pkg.
module sttok_checker (
  input logic        clk,
  input logic        rst,
  input logic        tok_valid,
  input logic        tok_ready,
  input logic [5:0]  tok_kind,
  input logic [15:0] tok_line,
  input logic        tok_last
);
  import sttok_pkg::*;

  // reset drops any waiting token
  a_reset_clears: assert property (@(posedge clk) rst |=> !tok_valid)
    else $error("token valid right after reset");

  a_kind_range: assert property (@(posedge clk) disable iff (rst)
    tok_valid |-> (tok_kind <= KIND_INVALID))
    else $error("token kind out of range");

  // tokens of one byte follow each other without a gap
  a_bundle_runs_on: assert property (@(posedge clk) disable iff (rst)
    tok_valid && tok_ready && !tok_last |=> tok_valid)
    else $error("token missing after a non-final transaction");

  a_bundle_same_line: assert property (@(posedge clk) disable iff (rst)
    tok_valid && tok_ready && !tok_last |=> tok_line == $past(tok_line))
    else $error("line changed inside the tokens of one byte");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    tok_valid && !tok_ready |=> tok_valid)
    else $error("token withdrawn while stalled");

endmodule

bind source_tokenizer_top sttok_checker u_sttok_checker (
  .clk       (clk),
  .rst       (rst),
  .tok_valid (tok.valid),
  .tok_ready (tok.ready),
  .tok_kind  (tok.token_kind),
  .tok_line  (tok.line_number),
  .tok_last  (tok.last)
);
